FILE: src/sha1_hash_top_assert.svh
// assertion macros for the sha1 hash block
`ifndef SHA1_HASH_TOP_ASSERT_SVH
`define SHA1_HASH_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha1 check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha1 check failed");

`endif

FILE: src/sha1_pkg.sv
package sha1_pkg;

	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned Rounds = 80;
	localparam int unsigned CountW = 61;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LenStart = 6'd56;
	localparam logic [5:0] BlockLast = 6'd63;
	localparam logic [2:0] WordLast = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic       start;
		logic       init_chain;
		logic       we;
		logic [5:0] addr;
		logic [7:0] data;
	} hash_ctl_t;

endpackage

FILE: src/sha1_if.sv
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

FILE: src/sha1_front.sv
module sha1_front #(
	parameter int unsigned QueueDepth = sha1_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	sha1_in_if.sink         msg,
	output logic            head_valid,
	output sha1_pkg::item_t head,
	input  logic            pop
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

	sha1_pkg::item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push;
	logic            do_pop;

	// items with neither a byte nor an end mark change nothing and are dropped
	assign msg.ready = (cnt_q != CntFull);
	assign push = msg.valid && msg.ready && (msg.byte_present || msg.end_of_message);
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_byte: msg.data_byte, byte_present: msg.byte_present,
				end_of_message: msg.end_of_message};
		end
	end

endmodule

FILE: src/sha1_round.sv
module sha1_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha1_pkg::hash_ctl_t ctl,
	output logic                busy,
	output logic [31:0]         chain [5]
);

	logic [31:0] h_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;
	logic [31:0] wx;
	logic [31:0] wnext;
	logic        last_step;

	assign busy = busy_q;
	assign chain = h_q;
	assign last_step = (rnd_q == 7'(sha1_pkg::Rounds));

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wnext = {wx[30:0], wx[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
			busy_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			if (ctl.init_chain) begin
				h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
					sha1_pkg::H4};
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					busy_q <= 1'b0;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	// the 16-word window doubles as the block store between compressions
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (busy_q && !last_step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnext;
		end
		if (ctl.we && !busy_q) begin
			w_q[ctl.addr[5:2]][{~ctl.addr[1:0], 3'b000} +: 8] <= ctl.data;
		end
	end

endmodule

FILE: src/sha1_back.sv
module sha1_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  sha1_pkg::item_t      head,
	output logic                 pop,
	output sha1_pkg::hash_ctl_t  ctl,
	input  logic                 busy,
	input  logic [31:0]          chain [5],
	sha1_out_if.source           digest
);

	typedef enum logic [1:0] {
		S_TAKE,
		S_HASH,
		S_PAD,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic [sha1_pkg::CountW-1:0]  cnt_q;
	logic [sha1_pkg::CountW-1:0]  cnt_n;
	logic [5:0]                   pad_pos_q;
	logic                         first_q;
	logic                         final_q;
	logic                         closing_q;
	logic                         eom_q;
	logic [2:0]                   idx_q;
	logic                         ovalid_q;
	logic [31:0]                  oword_q;
	logic [2:0]                   oindex_q;
	logic                         olast_q;
	logic [63:0]                  bits;
	logic [7:0]                   pad_byte;
	logic                         load;
	logic                         blk_full;

	assign digest.valid = ovalid_q;
	assign digest.digest_word = oword_q;
	assign digest.word_index = oindex_q;
	assign digest.last_word = olast_q;

	assign cnt_n = cnt_q + 1'b1;
	assign bits = {cnt_q, 3'b000};
	assign load = (state_q == S_OUT) && (!ovalid_q || digest.ready);
	assign blk_full = head.byte_present && (cnt_q[5:0] == sha1_pkg::BlockLast);

	always_comb begin
		if (first_q) begin
			pad_byte = sha1_pkg::PadMark;
		end else if (final_q && (pad_pos_q >= sha1_pkg::LenStart)) begin
			pad_byte = bits[{~pad_pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	always_comb begin
		pop = 1'b0;
		ctl = '0;
		case (state_q)
			S_TAKE: begin
				pop = head_valid;
				if (head_valid && head.byte_present) begin
					ctl.we = 1'b1;
					ctl.addr = cnt_q[5:0];
					ctl.data = head.data_byte;
					ctl.start = blk_full;
				end
			end
			S_PAD: begin
				ctl.we = 1'b1;
				ctl.addr = pad_pos_q;
				ctl.data = pad_byte;
				ctl.start = (pad_pos_q == sha1_pkg::BlockLast);
			end
			S_OUT: begin
				ctl.init_chain = load && (idx_q == sha1_pkg::WordLast);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			cnt_q <= '0;
			pad_pos_q <= '0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			closing_q <= 1'b0;
			eom_q <= 1'b0;
			idx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (digest.ready && !load) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_TAKE: begin
					if (head_valid) begin
						if (head.byte_present) begin
							cnt_q <= cnt_n;
						end
						if (blk_full) begin
							eom_q <= head.end_of_message;
							state_q <= S_HASH;
						end else if (head.end_of_message) begin
							pad_pos_q <= head.byte_present ? cnt_n[5:0] : cnt_q[5:0];
							final_q <= head.byte_present ? (cnt_n[5:0] < sha1_pkg::LenStart)
								: (cnt_q[5:0] < sha1_pkg::LenStart);
							first_q <= 1'b1;
							closing_q <= 1'b1;
							state_q <= S_PAD;
						end
					end
				end
				S_HASH: begin
					if (!busy) begin
						if (closing_q) begin
							if (final_q) begin
								idx_q <= '0;
								state_q <= S_OUT;
							end else begin
								pad_pos_q <= '0;
								final_q <= 1'b1;
								state_q <= S_PAD;
							end
						end else if (eom_q) begin
							pad_pos_q <= '0;
							first_q <= 1'b1;
							final_q <= 1'b1;
							closing_q <= 1'b1;
							eom_q <= 1'b0;
							state_q <= S_PAD;
						end else begin
							state_q <= S_TAKE;
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (pad_pos_q == sha1_pkg::BlockLast) begin
						state_q <= S_HASH;
					end else begin
						pad_pos_q <= pad_pos_q + 1'b1;
					end
				end
				S_OUT: begin
					if (load) begin
						ovalid_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
						if (idx_q == sha1_pkg::WordLast) begin
							cnt_q <= '0;
							closing_q <= 1'b0;
							final_q <= 1'b0;
							state_q <= S_TAKE;
						end
					end
				end
				default: begin
					state_q <= S_TAKE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oword_q <= chain[idx_q];
			oindex_q <= idx_q;
			olast_q <= (idx_q == sha1_pkg::WordLast);
		end
	end

endmodule

FILE: src/sha1_hash_top.sv
// SHA-1 over a byte stream. Each item on msg carries at most one byte and an
// optional end mark; an item with end_of_message set yields the 160-bit digest
// as five 32-bit words on digest (index 0 first, last_word on index 4), after
// which the block is ready for a new message. A small item queue sits in
// front, so bytes keep being taken while a block compresses. The hashing side
// writes each byte into the block store and runs each full 64-byte block
// through the shared one-round-per-cycle compression unit, then picks up its
// result. Closing a message takes the end item, pads the block with 0x80,
// zeros and the 64-bit bit length, uses a second block when the length no
// longer fits, compresses each block, and hands out the five digest words,
// holding each while digest is stalled. Items with neither a byte nor an end
// mark are dropped.
module sha1_hash_top #(
	parameter int unsigned QueueDepth = sha1_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	sha1_in_if.sink     msg,
	sha1_out_if.source  digest
);

	logic                head_valid;
	sha1_pkg::item_t     head;
	logic                pop;
	sha1_pkg::hash_ctl_t ctl;
	logic                busy;
	logic [31:0]         chain [5];

	sha1_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	sha1_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ctl        (ctl),
		.busy       (busy),
		.chain      (chain),
		.digest     (digest)
	);

	sha1_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (busy),
		.chain  (chain)
	);

endmodule

FILE: src/sha1_hash_chk.sv
`include "sha1_hash_top_assert.svh"

module sha1_hash_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	`SHA1_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index) && $stable(last_word))
	`SHA1_ASSERT_NOW(a_index_range, out_valid, word_index <= 3'd4)
	`SHA1_ASSERT_NOW(a_last_match, out_valid, last_word == (word_index == 3'd4))
	`SHA1_ASSERT_NEXT(a_word_order, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1))

endmodule

bind sha1_hash_top sha1_hash_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_index  (digest.word_index),
	.last_word   (digest.last_word)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	class digest_scoreboard;
		logic [31:0]  chain[5];
		logic [7:0]   store[64];
		logic [60:0]  byte_count;
		digest_word_t expected[$];
		int           mismatches;
		int           words_checked;
		int           messages;

		function new();
			mismatches = 0;
			words_checked = 0;
			messages = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = sha1_pkg::H0;
			chain[1] = sha1_pkg::H1;
			chain[2] = sha1_pkg::H2;
			chain[3] = sha1_pkg::H3;
			chain[4] = sha1_pkg::H4;
			foreach (store[i]) store[i] = 8'h00;
			byte_count = '0;
		endfunction

		function logic [31:0] rotl(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void compress();
			logic [31:0] w[80];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int r = 0; r < 16; r++)
				w[r] = {store[4*r], store[4*r+1], store[4*r+2], store[4*r+3]};
			for (int r = 16; r < 80; r++)
				w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = sha1_pkg::K0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = sha1_pkg::K1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = sha1_pkg::K2;
				end else begin
					f = b ^ c ^ d;
					k = sha1_pkg::K3;
				end
				t = rotl(a, 5) + f + e + k + w[r];
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void note_item(sha1_pkg::item_t it);
			int pos;
			logic [63:0] bits;
			digest_word_t dw;
			if (it.byte_present) begin
				pos = byte_count[5:0];
				store[pos] = it.data_byte;
				byte_count = byte_count + 1'b1;
				if (pos == sha1_pkg::BlockLast)
					compress();
			end
			if (!it.end_of_message)
				return;
			bits = {byte_count, 3'b000};
			pos = byte_count[5:0];
			store[pos] = sha1_pkg::PadMark;
			pos++;
			// length field no longer fits, pad out and use one more block
			if (pos > sha1_pkg::LenStart) begin
				while (pos < 64) store[pos++] = 8'h00;
				compress();
				pos = 0;
			end
			while (pos < sha1_pkg::LenStart) store[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				store[sha1_pkg::LenStart + i] = bits[63 - 8*i -: 8];
			compress();
			for (int i = 0; i <= sha1_pkg::WordLast; i++) begin
				dw.word = chain[i];
				dw.index = 3'(i);
				dw.last = (i == sha1_pkg::WordLast);
				expected.push_back(dw);
			end
			messages++;
			restart();
		endfunction

		function void check_word(logic [31:0] word, logic [2:0] index, logic last);
			digest_word_t want;
			words_checked++;
			if (expected.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: digest word %h index %0d last %0b with none expected",
						$realtime, word, index, last);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			if (word !== want.word || index !== want.index || last !== want.last) begin
				if (mismatches < 10)
					$display("%0t: expected word %h index %0d last %0b, got %h %0d %0b",
						$realtime, want.word, want.index, want.last, word, index, last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sha1_in_if  msg();
	sha1_out_if digest();

	digest_scoreboard sb;
	int  items_sent;
	bit  src_quiet;

	sha1_hash_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (digest)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
		sha1_pkg::item_t it;
		int gap;
		gap = src_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			msg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg.valid <= 1'b1;
		msg.data_byte <= b;
		msg.byte_present <= present;
		msg.end_of_message <= eom;
		@(posedge clk);
		while (!msg.ready) @(posedge clk);
		it.data_byte = b;
		it.byte_present = present;
		it.end_of_message = eom;
		sb.note_item(it);
		if (present || eom)
			items_sent++;
	endtask

	// random bytes, stray empty items, end mark either on the last byte or alone
	task automatic send_message(input int len);
		bit together;
		together = (len > 0) && ($urandom_range(0, 1) == 1);
		src_quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, together && (i == len - 1));
		end
		if (!together)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		digest.ready = 1'b0;
		wait (arst_n === 1'b1);
		begin
			int  stall_left;
			bit  quiet;
			stall_left = 0;
			quiet = 0;
			forever begin
				@(posedge clk);
				if (digest.valid && digest.ready)
					sb.check_word(digest.digest_word, digest.word_index, digest.last_word);
				if ($urandom_range(0, 99) == 0)
					quiet = !quiet;
				if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
					stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
				if (stall_left > 0) begin
					digest.ready <= 1'b0;
					stall_left--;
				end else begin
					digest.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int  random_items;
		int  len;
		bit  long_done;
		sb = new();
		items_sent = 0;
		src_quiet = 0;
		arst_n = 1'b0;
		msg.valid = 1'b0;
		msg.data_byte = 8'h00;
		msg.byte_present = 1'b0;
		msg.end_of_message = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray items, empty messages, extreme bytes, byte with end mark
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);

		random_items = 0;
		long_done = 0;
		while (random_items < 100 || !long_done) begin
			if ((!long_done && random_items >= 60) || $urandom_range(0, 9) < 2) begin
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					4: len = 119;
					default: len = 120;
				endcase
				long_done = 1;
			end else begin
				len = $urandom_range(0, 15);
			end
			send_message(len);
			random_items += len + 1;
		end
		msg.valid <= 1'b0;

		while (sb.expected.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("%0d items sent, %0d messages hashed, %0d digest words checked",
			items_sent, sb.messages, sb.words_checked);
		$display("message lengths covered empty, short, one-block and two-block padding");
		if (sb.mismatches == 0 && sb.expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
